[rtl/orw_pkg.sv]
// orw_pkg: shared constants, command codes and control/status types for the
// outstanding request window. No dependencies; used by every rtl file.
`default_nettype none

package orw_pkg;

    // Default window depth in slots
    localparam int WINDOW_DEF = 512;

    // Field widths
    localparam int ID_W         = 64;
    localparam int OP_W         = 2;
    localparam int BLOCK_SIZE_W = 10;
    localparam int BLOCK_SPAN   = 1 << BLOCK_SIZE_W;

    // Busy bits are kept in memory rows of ROW_BITS slots
    localparam int ROW_BITS  = 32;
    localparam int ROW_IDX_W = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC_ONE   = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC_BLOCK = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH      = 2'd2;

    // Datapath command codes
    localparam int CMD_W = 4;
    localparam logic [CMD_W-1:0] CMD_NONE       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_CAPTURE    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_DECODE     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ALLOC_WR   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REM_STEP   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_FIN_SLOT   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_FIN_RD     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_FIN_WR     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SCAN_START = 4'd8;
    localparam logic [CMD_W-1:0] CMD_SCAN_STEP  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_SCAN_FIN   = 4'd10;
    localparam logic [CMD_W-1:0] CMD_OUT_LOAD   = 4'd11;

    typedef struct packed {
        logic [CMD_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;          // captured operation
        logic            in_window;   // finish id lies inside the window
        logic            is_lowest;   // finish id equals the lowest unfinished id
        logic            rem_done;    // slot reduction on its last step
        logic            low_ge_next; // nothing outstanding above the low edge
        logic            scan_hit;    // busy slot found in the row under test
        logic            scan_last;   // row under test closes the circular sweep
        logic            out_free;    // output register can take a result
    } stat_t;

    // Number of busy-bit rows for a window
    function automatic int rows_of(input int w);
        return (w + ROW_BITS - 1) / ROW_BITS;
    endfunction

    // Highest shift k such that (w << k) stays below w + BLOCK_SPAN; the slot
    // reduction subtracts w << k for k from this value down to zero.
    function automatic int rem_steps(input int w);
        int k;
        k = 0;
        for (int i = 0; i < 12; i++)
        begin
            if ((w << (k + 1)) < w + BLOCK_SPAN)
                k = k + 1;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

[rtl/orw_slot_mem.sv]
// orw_slot_mem: busy-bit memory, one row of orw_pkg::ROW_BITS slots per address,
// with per-row valid flops so that rows never written read as clear.
`default_nettype none

module orw_slot_mem #(
    parameter  int ROWS = orw_pkg::rows_of(orw_pkg::WINDOW_DEF),
    localparam int ROWW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [ROWW-1:0]              rd_row,
    output logic      [orw_pkg::ROW_BITS-1:0] rd_data,
    input  wire logic                         wr_en,
    input  wire logic [ROWW-1:0]              wr_row,
    input  wire logic [orw_pkg::ROW_BITS-1:0] wr_data
);

    logic [orw_pkg::ROW_BITS-1:0] mem [ROWS];
    logic [orw_pkg::ROW_BITS-1:0] rd_data_reg;
    logic [ROWS-1:0]              row_valid_reg;
    logic                         rd_valid_reg;

    // Storage array, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_row] <= wr_data;
        rd_data_reg <= mem[rd_row];
    end

    // Row valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                row_valid_reg[wr_row] <= 1'b1;
            rd_valid_reg <= row_valid_reg[rd_row];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

[rtl/orw_dp.sv]
// orw_dp: datapath of the outstanding request window: id counters, slot
// indexes, slot reduction, busy-row scan and output register.
// Depends on orw_pkg and orw_slot_mem.
`default_nettype none

module orw_dp #(
    parameter int WINDOW = orw_pkg::WINDOW_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [orw_pkg::OP_W-1:0]         operation,
    input  wire logic [orw_pkg::ID_W-1:0]         rpc_id,
    input  wire logic [orw_pkg::BLOCK_SIZE_W-1:0] block_size,
    input  wire logic                             out_stall,
    output logic                                  out_valid,
    output logic      [orw_pkg::ID_W-1:0]         assigned_id,
    output logic      [orw_pkg::ID_W-1:0]         ack_id,
    output logic                                  window_full,
    input  wire orw_pkg::cmd_t                    cmd,
    output orw_pkg::stat_t                        stat
);

    localparam int ROWS  = orw_pkg::rows_of(WINDOW);
    localparam int ROWW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOTW = $clog2(ROWS * orw_pkg::ROW_BITS);
    localparam int REM_K = orw_pkg::rem_steps(WINDOW);
    localparam int KW    = (REM_K > 0) ? $clog2(REM_K + 1) : 1;
    localparam int REMW  = $clog2(WINDOW + orw_pkg::BLOCK_SPAN);
    localparam int CNTW  = $clog2(ROWS + 1);
    localparam int RB    = orw_pkg::ROW_BITS;
    localparam int IDW   = orw_pkg::ID_W;

    localparam logic [SLOTW:0]   WIN_S    = (SLOTW + 1)'(WINDOW);
    localparam logic [SLOTW-1:0] SLOT_MAX = SLOTW'(WINDOW - 1);
    localparam logic [ROWW-1:0]  ROW_MAX  = ROWW'(ROWS - 1);
    localparam logic [CNTW-1:0]  CNT_LAST = CNTW'(ROWS);

    // Captured transaction
    logic [orw_pkg::OP_W-1:0]         op_reg;
    logic [IDW-1:0]                   id_reg;
    logic [orw_pkg::BLOCK_SIZE_W-1:0] size_reg;

    // Window state
    logic [IDW-1:0]   low_reg,   low_next;
    logic [IDW-1:0]   next_reg,  next_next;
    logic [SLOTW-1:0] lslot_reg, lslot_next;
    logic [SLOTW-1:0] nslot_reg, nslot_next;

    // Per-transaction working registers
    logic [IDW-1:0]   asg_reg;
    logic             full_reg;
    logic [SLOTW-1:0] off_reg;
    logic             inwin_reg;
    logic             eq_reg;
    logic [SLOTW-1:0] fslot_reg;
    logic [REMW-1:0]  rem_reg;
    logic [KW-1:0]    k_reg;
    logic [ROWW-1:0]  scan_row_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic [SLOTW-1:0] dist_reg;
    logic [SLOTW-1:0] hit_slot_reg;
    logic             found_reg;

    // Output register
    logic           out_valid_reg;
    logic [IDW-1:0] asg_out_reg;
    logic [IDW-1:0] ack_out_reg;
    logic           full_out_reg;

    // Combinational terms
    logic                             full_now;
    logic [IDW-1:0]                   id_off;
    logic                             inwin_now;
    logic [orw_pkg::BLOCK_SIZE_W-1:0] incr;
    logic [REMW-1:0]                  rem_sub;
    logic [REMW-1:0]                  rem_next;
    logic [SLOTW:0]                   fsum;
    logic [SLOTW-1:0]                 fslot_now;
    logic [SLOTW-1:0]                 lslot_inc;
    logic [ROWW-1:0]                  scan_row_inc;
    logic [RB-1:0]                    ge_mask;
    logic [RB-1:0]                    scan_mask;
    logic [RB-1:0]                    hits;
    logic [orw_pkg::ROW_IDX_W-1:0]    hit_bit;
    logic                             hit_any;
    logic [SLOTW-1:0]                 hit_slot;
    logic [SLOTW:0]                   dist_wide;
    logic [IDW-1:0]                   gap;
    logic                             take_hit;
    logic                             out_free;

    // Memory port
    logic [ROWW-1:0] rd_row;
    logic [RB-1:0]   rd_data;
    logic            wr_en;
    logic [ROWW-1:0] wr_row;
    logic [RB-1:0]   wr_data;

    orw_slot_mem #(
        .ROWS (ROWS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_row  (rd_row),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_row  (wr_row),
        .wr_data (wr_data)
    );

    // Window tests
    assign full_now  = (next_reg >= low_reg) && ((next_reg - low_reg) >= IDW'(WINDOW));
    assign id_off    = id_reg - low_reg;
    assign inwin_now = (id_reg >= low_reg) && (id_off < IDW'(WINDOW));
    assign incr      = (op_reg == orw_pkg::OP_ALLOC_ONE) ? orw_pkg::BLOCK_SIZE_W'(1) : size_reg;

    // One restoring step of the slot reduction
    assign rem_sub  = REMW'(WINDOW) << k_reg;
    assign rem_next = (rem_reg >= rem_sub) ? (rem_reg - rem_sub) : rem_reg;

    // Slot of the finished id, relative to the low edge slot
    assign fsum      = {1'b0, lslot_reg} + {1'b0, off_reg};
    assign fslot_now = (fsum >= WIN_S) ? SLOTW'(fsum - WIN_S) : SLOTW'(fsum);
    assign lslot_inc = (lslot_reg == SLOT_MAX) ? '0 : (lslot_reg + SLOTW'(1));

    // Circular sweep: first row keeps bits at or above the start slot, the
    // closing pass over the same row keeps the bits below it
    assign scan_row_inc = (scan_row_reg == ROW_MAX) ? '0 : (scan_row_reg + ROWW'(1));
    assign ge_mask      = {RB{1'b1}} << lslot_reg[orw_pkg::ROW_IDX_W-1:0];

    always_comb
    begin
        scan_mask = {RB{1'b1}};
        if (cnt_reg == '0)
            scan_mask = scan_mask & ge_mask;
        if (cnt_reg == CNT_LAST)
            scan_mask = scan_mask & ~ge_mask;
    end

    assign hits    = rd_data & scan_mask;
    assign hit_any = |hits;

    // Lowest set bit of the masked row
    always_comb
    begin
        hit_bit = '0;
        for (int i = RB - 1; i >= 0; i--)
        begin
            if (hits[i])
                hit_bit = orw_pkg::ROW_IDX_W'(i);
        end
    end

    assign hit_slot  = SLOTW'({scan_row_reg, hit_bit});
    assign dist_wide = (hit_slot >= lslot_reg)
                     ? ({1'b0, hit_slot} - {1'b0, lslot_reg})
                     : ({1'b0, hit_slot} + WIN_S - {1'b0, lslot_reg});

    assign gap      = next_reg - low_reg;
    assign take_hit = found_reg && (IDW'(dist_reg) < gap);
    assign out_free = !out_valid_reg || !out_stall;

    // Memory addressing
    always_comb
    begin
        unique case (cmd.code)
            orw_pkg::CMD_DECODE:     rd_row = ROWW'(nslot_reg >> orw_pkg::ROW_IDX_W);
            orw_pkg::CMD_FIN_RD:     rd_row = ROWW'(fslot_reg >> orw_pkg::ROW_IDX_W);
            orw_pkg::CMD_SCAN_START: rd_row = ROWW'(lslot_reg >> orw_pkg::ROW_IDX_W);
            orw_pkg::CMD_SCAN_STEP:  rd_row = scan_row_inc;
            default:                 rd_row = '0;
        endcase
    end

    assign wr_en  = (cmd.code == orw_pkg::CMD_ALLOC_WR) || (cmd.code == orw_pkg::CMD_FIN_WR);
    assign wr_row = (cmd.code == orw_pkg::CMD_ALLOC_WR)
                  ? ROWW'(nslot_reg >> orw_pkg::ROW_IDX_W)
                  : ROWW'(fslot_reg >> orw_pkg::ROW_IDX_W);
    assign wr_data = (cmd.code == orw_pkg::CMD_ALLOC_WR)
                   ? (rd_data | (RB'(1) << nslot_reg[orw_pkg::ROW_IDX_W-1:0]))
                   : (rd_data & ~(RB'(1) << fslot_reg[orw_pkg::ROW_IDX_W-1:0]));

    // Next window state
    always_comb
    begin
        low_next   = low_reg;
        next_next  = next_reg;
        lslot_next = lslot_reg;
        nslot_next = nslot_reg;
        case (cmd.code)
            orw_pkg::CMD_ALLOC_WR:
                next_next = next_reg + IDW'(incr);
            orw_pkg::CMD_REM_STEP:
            begin
                if (k_reg == '0)
                    nslot_next = SLOTW'(rem_next);
            end
            orw_pkg::CMD_FIN_WR:
            begin
                if (eq_reg)
                begin
                    low_next   = low_reg + IDW'(1);
                    lslot_next = lslot_inc;
                end
            end
            orw_pkg::CMD_SCAN_FIN:
            begin
                if (take_hit)
                begin
                    low_next   = low_reg + IDW'(dist_reg);
                    lslot_next = hit_slot_reg;
                end
                else
                begin
                    low_next   = next_reg;
                    lslot_next = nslot_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= IDW'(1);
            next_reg      <= IDW'(1);
            lslot_reg     <= SLOTW'(1);
            nslot_reg     <= SLOTW'(1);
            k_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            low_reg   <= low_next;
            next_reg  <= next_next;
            lslot_reg <= lslot_next;
            nslot_reg <= nslot_next;
            if (cmd.code == orw_pkg::CMD_ALLOC_WR)
                k_reg <= KW'(REM_K);
            else if ((cmd.code == orw_pkg::CMD_REM_STEP) && (k_reg != '0))
                k_reg <= k_reg - KW'(1);
            if (cmd.code == orw_pkg::CMD_SCAN_START)
                cnt_reg <= '0;
            else if ((cmd.code == orw_pkg::CMD_SCAN_STEP) && (cnt_reg != CNT_LAST))
                cnt_reg <= cnt_reg + CNTW'(1);
            if (cmd.code == orw_pkg::CMD_OUT_LOAD)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.code)
            orw_pkg::CMD_CAPTURE:
            begin
                op_reg   <= operation;
                id_reg   <= rpc_id;
                size_reg <= block_size;
            end
            orw_pkg::CMD_DECODE:
            begin
                if ((op_reg == orw_pkg::OP_ALLOC_ONE) || (op_reg == orw_pkg::OP_ALLOC_BLOCK))
                begin
                    asg_reg  <= next_reg;
                    full_reg <= full_now;
                end
                else
                begin
                    asg_reg  <= '0;
                    full_reg <= 1'b0;
                end
                off_reg   <= SLOTW'(id_off);
                inwin_reg <= inwin_now;
                eq_reg    <= (id_reg == low_reg);
            end
            orw_pkg::CMD_ALLOC_WR:
                rem_reg <= REMW'(nslot_reg) + REMW'(incr);
            orw_pkg::CMD_REM_STEP:
                rem_reg <= rem_next;
            orw_pkg::CMD_FIN_SLOT:
                fslot_reg <= fslot_now;
            orw_pkg::CMD_SCAN_START:
                scan_row_reg <= ROWW'(lslot_reg >> orw_pkg::ROW_IDX_W);
            orw_pkg::CMD_SCAN_STEP:
            begin
                scan_row_reg <= scan_row_inc;
                dist_reg     <= SLOTW'(dist_wide);
                hit_slot_reg <= hit_slot;
                found_reg    <= hit_any;
            end
            orw_pkg::CMD_OUT_LOAD:
            begin
                asg_out_reg  <= asg_reg;
                ack_out_reg  <= low_reg - IDW'(1);
                full_out_reg <= full_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Status to the controller
    assign stat.op          = op_reg;
    assign stat.in_window   = inwin_reg;
    assign stat.is_lowest   = eq_reg;
    assign stat.rem_done    = (k_reg == '0);
    assign stat.low_ge_next = (low_reg >= next_reg);
    assign stat.scan_hit    = hit_any;
    assign stat.scan_last   = (cnt_reg == CNT_LAST);
    assign stat.out_free    = out_free;

    assign out_valid   = out_valid_reg;
    assign assigned_id = asg_out_reg;
    assign ack_id      = ack_out_reg;
    assign window_full = full_out_reg;

    // Slot indexes always name a slot inside the window
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (lslot_reg <= SLOT_MAX) && (nslot_reg <= SLOT_MAX))
        else $error("slot index outside window");

    // Sweep counter never runs past the closing row
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("scan counter overran");

    // A loaded result carries the ack of the low edge at load time
    a_ack_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == orw_pkg::CMD_OUT_LOAD) |=>
            (out_valid_reg && (ack_out_reg == $past(low_reg) - IDW'(1))))
        else $error("result ack mismatch");

endmodule

`default_nettype wire

[rtl/orw_ctrl.sv]
// orw_ctrl: sequencing state machine of the outstanding request window.
// Issues orw_pkg::cmd_t commands to orw_dp and branches on orw_pkg::stat_t.
`default_nettype none

module orw_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire orw_pkg::stat_t stat,
    output orw_pkg::cmd_t       cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_ALLOC_WR = 4'd2;
    localparam logic [3:0] ST_REM      = 4'd3;
    localparam logic [3:0] ST_FIN_SLOT = 4'd4;
    localparam logic [3:0] ST_FIN_RD   = 4'd5;
    localparam logic [3:0] ST_FIN_WR   = 4'd6;
    localparam logic [3:0] ST_SCAN_CHK = 4'd7;
    localparam logic [3:0] ST_SCAN     = 4'd8;
    localparam logic [3:0] ST_SCAN_FIN = 4'd9;
    localparam logic [3:0] ST_OUT      = 4'd10;

    logic [3:0] state_reg, state_next;

    // Next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd.code   = orw_pkg::CMD_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.code   = orw_pkg::CMD_CAPTURE;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.code = orw_pkg::CMD_DECODE;
                unique case (stat.op) inside
                    orw_pkg::OP_ALLOC_ONE, orw_pkg::OP_ALLOC_BLOCK: state_next = ST_ALLOC_WR;
                    orw_pkg::OP_FINISH:                             state_next = ST_FIN_SLOT;
                    default:                                        state_next = ST_OUT;
                endcase
            end
            ST_ALLOC_WR:
            begin
                cmd.code   = orw_pkg::CMD_ALLOC_WR;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                cmd.code = orw_pkg::CMD_REM_STEP;
                if (stat.rem_done)
                    state_next = ST_OUT;
            end
            ST_FIN_SLOT:
            begin
                cmd.code   = orw_pkg::CMD_FIN_SLOT;
                state_next = stat.in_window ? ST_FIN_RD : ST_OUT;
            end
            ST_FIN_RD:
            begin
                cmd.code   = orw_pkg::CMD_FIN_RD;
                state_next = ST_FIN_WR;
            end
            ST_FIN_WR:
            begin
                cmd.code   = orw_pkg::CMD_FIN_WR;
                state_next = stat.is_lowest ? ST_SCAN_CHK : ST_OUT;
            end
            ST_SCAN_CHK:
            begin
                if (stat.low_ge_next)
                    state_next = ST_OUT;
                else
                begin
                    cmd.code   = orw_pkg::CMD_SCAN_START;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.code = orw_pkg::CMD_SCAN_STEP;
                if (stat.scan_hit || stat.scan_last)
                    state_next = ST_SCAN_FIN;
            end
            ST_SCAN_FIN:
            begin
                cmd.code   = orw_pkg::CMD_SCAN_FIN;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.code   = orw_pkg::CMD_OUT_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

    // An accepted transaction always goes to decode next
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_DECODE) && in_stall)
        else $error("accept did not start decode");

    // A result is loaded only when the output register is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == orw_pkg::CMD_OUT_LOAD) |-> stat.out_free)
        else $error("result loaded over a pending one");

endmodule

`default_nettype wire

[rtl/outstanding_request_window.sv]
// Outstanding request window, one transaction at a time. Allocate: decode, busy-bit
// write, reduction steps orw_pkg::rem_steps(WINDOW) (1 at 512 slots) to 0; finish:
// decode, slot step, inside the window row read and write, then on the lowest id a
// busy-row sweep, one row per cycle; unused codes: decode, output. The next
// transaction is taken in the cycle after the load; a stalled result holds it.
// rst_n (async, active low) sets both ids to one and clears all busy rows.
`default_nettype none

module outstanding_request_window #(
    parameter int WINDOW = orw_pkg::WINDOW_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [orw_pkg::OP_W-1:0]         operation,
    input  wire logic [orw_pkg::ID_W-1:0]         rpc_id,
    input  wire logic [orw_pkg::BLOCK_SIZE_W-1:0] block_size,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [orw_pkg::ID_W-1:0]         assigned_id,
    output logic      [orw_pkg::ID_W-1:0]         ack_id,
    output logic                                  window_full
);

    orw_pkg::cmd_t  cmd;
    orw_pkg::stat_t stat;

    orw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    orw_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .rpc_id      (rpc_id),
        .block_size  (block_size),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .assigned_id (assigned_id),
        .ack_id      (ack_id),
        .window_full (window_full),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire
